/* rtl/core/first_fit_heap_allocator_assert.svh */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator assertion macros
// shared assertion forms, clocked on clock and disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffha assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffha assertion failed");

`endif

/* rtl/core/ffha_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_pkg
// shared field widths, command and status codes, result bundle
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int FIELD_W  = 17;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // requests are rounded up to a multiple of this mask plus one
   localparam int ROUND_MASK = 3;
   // a split leaves a free block only above header plus this many bytes
   localparam int SPLIT_SLACK = 4;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NULL = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [FIELD_W-1:0]  offset;
      logic [STATUS_W-1:0] status;
   } ffha_result_type;

endpackage

/* rtl/core/ffha_hdr_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_hdr_mem
// header ram: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module ffha_hdr_mem #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 18,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] hdr_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hdr_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ffha_ctrl.sv */
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
// ---------------------------------------------------------------------------
// ffha_ctrl
// command sequencer: first-fit walk, split, bump, free and merge pass
// ---------------------------------------------------------------------------
module ffha_ctrl #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 8,
   localparam int GRAN   = (HEADER_BYTES % 4 == 0) ? 4 : ((HEADER_BYTES % 2 == 0) ? 2 : 1),
   localparam int DEPTH  = (HEAP_BYTES + GRAN - 1) / GRAN,
   localparam int AW     = $clog2(DEPTH),
   localparam int SIZE_W = $clog2(HEAP_BYTES + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ffha_pkg::CMD_W-1:0]       req_command,
   input  logic [ffha_pkg::FIELD_W-1:0]     req_alloc_size,
   input  logic [ffha_pkg::FIELD_W-1:0]     req_block_offset,
   output logic                             ready,
   output ffha_pkg::ffha_result_type        res,
   input  logic                             take,
   output logic                             hdr_wr_en,
   output logic [AW-1:0]                    hdr_wr_addr,
   output logic [SIZE_W:0]                  hdr_wr_data,
   output logic                             hdr_rd_en,
   output logic [AW-1:0]                    hdr_rd_addr,
   input  logic [SIZE_W:0]                  hdr_rd_data
);

   import ffha_pkg::*;

   localparam int GRAN_SH = $clog2(GRAN);
   localparam int BASE_W  = (SIZE_W > FIELD_W) ? SIZE_W : FIELD_W;
   localparam int POS_W   = BASE_W + 2;

   localparam logic [POS_W-1:0]  HDR     = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0]  HEAP_P  = POS_W'(HEAP_BYTES);
   localparam logic [POS_W-1:0]  SPLIT_P = POS_W'(HEADER_BYTES + SPLIT_SLACK);
   localparam logic [POS_W-1:0]  RND_P   = POS_W'(ROUND_MASK);
   localparam logic [SIZE_W-1:0] HEAP_SZ = SIZE_W'(HEAP_BYTES);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_FIT_CHK  = 10'b00_0000_0010,
      S_FIT_EVAL = 10'b00_0000_0100,
      S_SPLIT    = 10'b00_0000_1000,
      S_FREE_WR  = 10'b00_0001_0000,
      S_MRG_CHK  = 10'b00_0010_0000,
      S_MRG_CUR  = 10'b00_0100_0000,
      S_MRG_ADV  = 10'b00_1000_0000,
      S_MRG_NXT  = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   function automatic logic [AW-1:0] to_idx(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] g;
      g = pos >> GRAN_SH;
      return g[AW-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  top_ff, top_in;
   logic [POS_W-1:0]   cur_ff, cur_in;
   logic [POS_W-1:0]   nxt_ff, nxt_in;
   logic [POS_W-1:0]   need_ff, need_in;
   logic [SIZE_W-1:0]  csize_ff, csize_in;
   logic               cfree_ff, cfree_in;
   logic [FIELD_W-1:0] res_off_ff, res_off_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;

   logic [POS_W-1:0]  top_ext, off_ext, off_hdr, need_calc, rd_size_ext;
   logic [POS_W-1:0]  fit_next, bump_end, split_pos, adv_nxt, mrg_sum, rest_ext;
   logic [SIZE_W-1:0] rd_size, rest, mrg_sat;
   logic              rd_free, free_in_range, free_aligned;
   logic              rd_wait_state;

   assign top_ext     = POS_W'(top_ff);
   assign off_ext     = POS_W'(req_block_offset);
   assign off_hdr     = off_ext - HDR;
   assign need_calc   = (POS_W'(req_alloc_size) + RND_P) & ~RND_P;
   assign rd_size     = hdr_rd_data[SIZE_W-1:0];
   assign rd_free     = hdr_rd_data[SIZE_W];
   assign rd_size_ext = POS_W'(rd_size);

   assign free_in_range = (off_ext >= HDR) && (off_hdr < HEAP_P);
   assign free_aligned  = (off_hdr % GRAN) == '0;

   assign fit_next  = cur_ff + HDR + rd_size_ext;
   assign bump_end  = top_ext + HDR + need_ff;
   assign split_pos = cur_ff + HDR + need_ff;
   assign rest      = rd_size - need_ff[SIZE_W-1:0];
   assign rest_ext  = POS_W'(rest);
   assign adv_nxt   = cur_ff + HDR + POS_W'(csize_ff);
   assign mrg_sum   = POS_W'(csize_ff) + HDR + rd_size_ext;
   assign mrg_sat   = (mrg_sum >= HEAP_P) ? HEAP_SZ : mrg_sum[SIZE_W-1:0];

   always_comb begin
      state_in    = state_ff;
      top_in      = top_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      need_in     = need_ff;
      csize_in    = csize_ff;
      cfree_in    = cfree_ff;
      res_off_in  = res_off_ff;
      res_st_in   = res_st_ff;
      hdr_wr_en   = 1'b0;
      hdr_wr_addr = '0;
      hdr_wr_data = '0;
      hdr_rd_en   = 1'b0;
      hdr_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_off_in = '0;
               res_st_in  = ST_OK;
               unique case (req_command)
                  CMD_ALLOC: begin
                     if (req_alloc_size == '0) begin
                        res_st_in = ST_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        need_in  = need_calc;
                        cur_in   = '0;
                        state_in = S_FIT_CHK;
                     end
                  end
                  CMD_FREE: begin
                     if (req_block_offset == '0) begin
                        res_st_in = ST_NULL;
                        state_in  = S_DONE;
                     end else if (!free_in_range) begin
                        state_in = S_DONE;
                     end else if (free_aligned) begin
                        // fetch the header to set its free flag
                        hdr_rd_en   = 1'b1;
                        hdr_rd_addr = to_idx(off_hdr);
                        cur_in      = off_hdr;
                        state_in    = S_FREE_WR;
                     end else begin
                        // entry off the granule grid is never on the chain
                        cur_in   = '0;
                        state_in = S_MRG_CHK;
                     end
                  end
                  CMD_INIT: begin
                     top_in   = '0;
                     state_in = S_DONE;
                  end
                  CMD_NOP: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_FIT_CHK: begin
            if (cur_ff < top_ext) begin
               hdr_rd_en   = 1'b1;
               hdr_rd_addr = to_idx(cur_ff);
               state_in    = S_FIT_EVAL;
            end else if (bump_end > HEAP_P) begin
               res_st_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               hdr_wr_en   = 1'b1;
               hdr_wr_addr = to_idx(top_ext);
               hdr_wr_data = {1'b0, need_ff[SIZE_W-1:0]};
               res_off_in  = FIELD_W'(top_ext + HDR);
               top_in      = bump_end[SIZE_W-1:0];
               state_in    = S_DONE;
            end
         end

         S_FIT_EVAL: begin
            if (rd_free && (rd_size_ext >= need_ff)) begin
               res_off_in = FIELD_W'(cur_ff + HDR);
               if (rest_ext > SPLIT_P) begin
                  hdr_wr_en   = split_pos < HEAP_P;
                  hdr_wr_addr = to_idx(split_pos);
                  hdr_wr_data = {1'b1, rest - SIZE_W'(HEADER_BYTES)};
                  state_in    = S_SPLIT;
               end else begin
                  hdr_wr_en   = 1'b1;
                  hdr_wr_addr = to_idx(cur_ff);
                  hdr_wr_data = {1'b0, rd_size};
                  state_in    = S_DONE;
               end
            end else begin
               cur_in   = fit_next;
               state_in = S_FIT_CHK;
            end
         end

         S_SPLIT: begin
            hdr_wr_en   = 1'b1;
            hdr_wr_addr = to_idx(cur_ff);
            hdr_wr_data = {1'b0, need_ff[SIZE_W-1:0]};
            state_in    = S_DONE;
         end

         S_FREE_WR: begin
            hdr_wr_en   = 1'b1;
            hdr_wr_addr = to_idx(cur_ff);
            hdr_wr_data = {1'b1, rd_size};
            cur_in      = '0;
            state_in    = S_MRG_CHK;
         end

         S_MRG_CHK: begin
            if (cur_ff < top_ext) begin
               hdr_rd_en   = 1'b1;
               hdr_rd_addr = to_idx(cur_ff);
               state_in    = S_MRG_CUR;
            end else begin
               state_in = S_DONE;
            end
         end

         S_MRG_CUR: begin
            csize_in = rd_size;
            cfree_in = rd_free;
            state_in = S_MRG_ADV;
         end

         S_MRG_ADV: begin
            if (adv_nxt >= top_ext) begin
               state_in = S_DONE;
            end else begin
               hdr_rd_en   = 1'b1;
               hdr_rd_addr = to_idx(adv_nxt);
               nxt_in      = adv_nxt;
               state_in    = S_MRG_NXT;
            end
         end

         S_MRG_NXT: begin
            if (cfree_ff && rd_free) begin
               // absorb the neighbor, keep the merged size locally
               hdr_wr_en   = 1'b1;
               hdr_wr_addr = to_idx(cur_ff);
               hdr_wr_data = {1'b1, mrg_sat};
               csize_in    = mrg_sat;
               state_in    = (mrg_sum >= HEAP_P) ? S_DONE : S_MRG_ADV;
            end else begin
               cur_in   = nxt_ff;
               csize_in = rd_size;
               cfree_in = rd_free;
               state_in = S_MRG_ADV;
            end
         end

         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      need_ff    <= need_in;
      csize_ff   <= csize_in;
      cfree_ff   <= cfree_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
   end

   assign ready      = state_ff == S_IDLE;
   assign res.valid  = state_ff == S_DONE;
   assign res.offset = res_off_ff;
   assign res.status = res_st_ff;

   // states that consume the header read issued in the previous cycle
   assign rd_wait_state = (state_ff == S_FIT_EVAL) || (state_ff == S_FREE_WR) ||
                          (state_ff == S_MRG_CUR)  || (state_ff == S_MRG_NXT);

   `FFHA_ASSERT_NOW(a_top_in_heap, 1'b1, top_ff <= HEAP_SZ)
   `FFHA_ASSERT_NOW(a_no_rw_clash, hdr_wr_en && hdr_rd_en, hdr_wr_addr != hdr_rd_addr)
   `FFHA_ASSERT_NEXT(a_read_consumed, hdr_rd_en, rd_wait_state)
   `FFHA_ASSERT_NOW(a_fail_no_offset, state_ff == S_DONE && res_st_ff != ST_OK, res_off_ff == '0)

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// init, zero size, null or out-of-range free and unused command finish without touching the
// header ram; allocate walks the headers first-fit, then bumps the top or reuses a block,
// with or without a split; free sets the free flag, then a merge pass reads neighbor headers
// free off the granule grid skips the header update and goes straight to the merge pass
// one item at a time: the next item is accepted only after the result enters the output register
// reset clears the top pointer and control only; the header ram is not cleared
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap allocator with in-band headers and free-block coalescing
// ---------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ffha_pkg::CMD_W-1:0]      req_command,
   input  logic [ffha_pkg::FIELD_W-1:0]    req_alloc_size,
   input  logic [ffha_pkg::FIELD_W-1:0]    req_block_offset,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffha_pkg::FIELD_W-1:0]    rsp_result_offset,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status
);

   import ffha_pkg::*;

   // header granule: headers always sit on this alignment
   localparam int GRAN   = (HEADER_BYTES % 4 == 0) ? 4 : ((HEADER_BYTES % 2 == 0) ? 2 : 1);
   localparam int DEPTH  = (HEAP_BYTES + GRAN - 1) / GRAN;
   localparam int AW     = $clog2(DEPTH);
   localparam int SIZE_W = $clog2(HEAP_BYTES + 1);

   // header ram interface: {free flag, block size}
   logic              hdr_wr_en;
   logic [AW-1:0]     hdr_wr_addr;
   logic [SIZE_W:0]   hdr_wr_data;
   logic              hdr_rd_en;
   logic [AW-1:0]     hdr_rd_addr;
   logic [SIZE_W:0]   hdr_rd_data;

   ffha_result_type   core_res;
   logic              core_ready;
   logic              req_accept;
   logic              rsp_load;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_offset_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // a new item enters only while the sequencer sits idle
   assign req_stall  = !core_ready;
   assign req_accept = req_valid && !req_stall;

   ffha_hdr_mem #(
      .DEPTH (DEPTH),
      .WIDTH (SIZE_W + 1)
   ) u_hdr_mem (
      .clock   (clock),
      .wr_en   (hdr_wr_en),
      .wr_addr (hdr_wr_addr),
      .wr_data (hdr_wr_data),
      .rd_en   (hdr_rd_en),
      .rd_addr (hdr_rd_addr),
      .rd_data (hdr_rd_data)
   );

   ffha_ctrl #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (req_accept),
      .req_command      (req_command),
      .req_alloc_size   (req_alloc_size),
      .req_block_offset (req_block_offset),
      .ready            (core_ready),
      .res              (core_res),
      .take             (rsp_load),
      .hdr_wr_en        (hdr_wr_en),
      .hdr_wr_addr      (hdr_wr_addr),
      .hdr_wr_data      (hdr_wr_data),
      .hdr_rd_en        (hdr_rd_en),
      .hdr_rd_addr      (hdr_rd_addr),
      .hdr_rd_data      (hdr_rd_data)
   );

   // the finished item moves into the output register when it is empty or draining,
   // which frees the sequencer to accept the next item while this one waits
   assign rsp_load     = core_res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds unless a new item is loaded
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_offset_ff <= core_res.offset;
         rsp_status_ff <= core_res.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_status        = rsp_status_ff;

   // an accepted item keeps the sequencer busy on the following cycle
   `FFHA_ASSERT_NEXT(a_accept_busy, req_accept, req_stall)
   // a response only appears after the sequencer presented a finished item
   `FFHA_ASSERT_NOW(a_rsp_from_core, $rose(rsp_valid_ff), $past(core_res.valid))
   // a finished item that is not taken stays put
   `FFHA_ASSERT_NEXT(a_core_holds, core_res.valid && !rsp_load, $stable(core_res))

endmodule
